// ===== src/lsp_pkg.sv =====
// Package for the lidar scan to points block: shared types, codes and constants.
// Holds the register map, the command/status structs and the CORDIC angle table.
// No dependencies.
package lsp_pkg;

    // Register map, word index taken from paddr[4:2]
    localparam logic [2:0] REG_ANGLE_START = 3'd0;
    localparam logic [2:0] REG_ANGLE_INC   = 3'd1;
    localparam logic [2:0] REG_RANGE_MIN   = 3'd2;
    localparam logic [2:0] REG_RANGE_MAX   = 3'd3;
    localparam logic [2:0] REG_PIXEL_SCALE = 3'd4;
    localparam logic [2:0] REG_IMG_DIM     = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_RANGE_MIN   = 16'd50;
    localparam logic [15:0] RST_RANGE_MAX   = 16'd50000;
    localparam logic [15:0] RST_PIXEL_SCALE = 16'd3277;
    localparam logic [11:0] RST_IMG_DIM     = 12'd800;

    // CORDIC gain compensation, Q0.16
    localparam logic [15:0] GAIN_Q16 = 16'd39797;
    // Width of the CORDIC x/y working registers
    localparam int          XY_W     = 35;
    // Width of the pixel projection sum
    localparam int          PIX_W    = 35;

    typedef struct packed {
        logic [15:0] angle_start;
        logic [15:0] angle_inc;
        logic [15:0] range_min;
        logic [15:0] range_max;
        logic [15:0] pixel_scale;
        logic [11:0] img_dim;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ITER,
        ST_ROUND,
        ST_PIX_U,
        ST_PIX_V,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic prep;
        logic iter;
        logic round;
        logic pix_u;
        logic pix_v;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic kept;
        logic last;
        logic iter_last;
        logic out_free;
    } t_sts;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] res;
        unique case (idx)
            5'd0:    res = 32'h2000_0000;
            5'd1:    res = 32'h12E4_051E;
            5'd2:    res = 32'h09FB_385B;
            5'd3:    res = 32'h0511_11D4;
            5'd4:    res = 32'h028B_0D43;
            5'd5:    res = 32'h0145_D7E1;
            5'd6:    res = 32'h00A2_F61E;
            5'd7:    res = 32'h0051_7C55;
            5'd8:    res = 32'h0028_BE53;
            5'd9:    res = 32'h0014_5F2F;
            5'd10:   res = 32'h000A_2F98;
            5'd11:   res = 32'h0005_17CC;
            5'd12:   res = 32'h0002_8BE6;
            5'd13:   res = 32'h0001_45F3;
            5'd14:   res = 32'h0000_A2FA;
            5'd15:   res = 32'h0000_517D;
            5'd16:   res = 32'h0000_28BE;
            5'd17:   res = 32'h0000_145F;
            5'd18:   res = 32'h0000_0A30;
            5'd19:   res = 32'h0000_0518;
            5'd20:   res = 32'h0000_028C;
            5'd21:   res = 32'h0000_0146;
            5'd22:   res = 32'h0000_00A3;
            5'd23:   res = 32'h0000_0051;
            default: res = 32'h0000_0000;
        endcase
        return res;
    endfunction

endpackage

// ===== src/lsp_regs.sv =====
// Configuration register file for the lidar scan to points block.
// APB-style write/read access; depends on lsp_pkg for the register map.
module lsp_regs import lsp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_start <= '0;
            r_cfg.angle_inc   <= '0;
            r_cfg.range_min   <= RST_RANGE_MIN;
            r_cfg.range_max   <= RST_RANGE_MAX;
            r_cfg.pixel_scale <= RST_PIXEL_SCALE;
            r_cfg.img_dim     <= RST_IMG_DIM;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ANGLE_START: r_cfg.angle_start <= pwdata[15:0];
                REG_ANGLE_INC:   r_cfg.angle_inc   <= pwdata[15:0];
                REG_RANGE_MIN:   r_cfg.range_min   <= pwdata[15:0];
                REG_RANGE_MAX:   r_cfg.range_max   <= pwdata[15:0];
                REG_PIXEL_SCALE: r_cfg.pixel_scale <= pwdata[15:0];
                REG_IMG_DIM:     r_cfg.img_dim     <= pwdata[11:0];
                default: begin
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_ANGLE_START: prdata = {16'h0, r_cfg.angle_start};
            REG_ANGLE_INC:   prdata = {16'h0, r_cfg.angle_inc};
            REG_RANGE_MIN:   prdata = {16'h0, r_cfg.range_min};
            REG_RANGE_MAX:   prdata = {16'h0, r_cfg.range_max};
            REG_PIXEL_SCALE: prdata = {16'h0, r_cfg.pixel_scale};
            REG_IMG_DIM:     prdata = {20'h0, r_cfg.img_dim};
            default:         prdata = 32'h0;
        endcase
    end

endmodule

// ===== src/lsp_ctrl.sv =====
// Controller state machine for the lidar scan to points block.
// Sequences accept, CORDIC iterations, rounding, projection and output; uses lsp_pkg.
module lsp_ctrl import lsp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                // hold off the sender while in reset
                o_stall = !i_rst_n;
                if (i_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                priority if (i_sts.kept) begin
                    n_state = ST_ITER;
                end else if (i_sts.last) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ITER: begin
                o_cmd.iter = 1'b1;
                if (i_sts.iter_last) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = ST_PIX_U;
            end
            ST_PIX_U: begin
                o_cmd.pix_u = 1'b1;
                n_state     = ST_PIX_V;
            end
            ST_PIX_V: begin
                o_cmd.pix_v = 1'b1;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lsp_dp.sv =====
// Datapath for the lidar scan to points block: scan state, range gate, iterative
// CORDIC, rounding, pixel projection and the output word register; uses lsp_pkg.
module lsp_dp import lsp_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_BITS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [15:0]        i_range_mm,
    input  logic               i_range_bad,
    input  logic               i_scan_last,
    input  logic               i_stall,
    output logic               o_valid,
    output logic signed [16:0] o_point_x_mm,
    output logic signed [16:0] o_point_y_mm,
    output logic [11:0]        o_pixel_u,
    output logic [11:0]        o_pixel_v,
    output logic               o_on_image,
    output logic               o_point_valid,
    output logic               o_scan_end,
    output logic               o_scan_empty
);

    localparam int                CNT_W     = $clog2(CORDIC_STEPS);
    localparam logic [CNT_W-1:0]  LAST_ITER = CNT_W'(CORDIC_STEPS - 1);
    localparam int                PAD_W     = 32 - ANGLE_BITS;

    // Scan state
    logic [ANGLE_BITS-1:0] r_cur_angle;
    logic                  r_at_start;
    logic                  r_any_kept;

    // Current word
    logic [15:0]           r_range;
    logic [ANGLE_BITS-1:0] r_ang;
    logic                  r_kept;
    logic                  r_last;
    logic                  r_empty;

    // CORDIC state
    logic signed [XY_W-1:0] r_x;
    logic signed [XY_W-1:0] r_y;
    logic signed [32:0]     r_z;
    logic [CNT_W-1:0]       r_cnt;

    // Rounded point and pixel
    logic signed [16:0] r_x_mm;
    logic signed [16:0] r_y_mm;
    logic [11:0]        r_u;
    logic [11:0]        r_v;
    logic               r_u_ok;
    logic               r_on;

    // Output word
    logic               r_out_valid;
    logic signed [16:0] r_out_x;
    logic signed [16:0] r_out_y;
    logic [11:0]        r_out_u;
    logic [11:0]        r_out_v;
    logic               r_out_on;
    logic               r_out_pv;
    logic               r_out_end;
    logic               r_out_empty;

    logic [31:0]            start32;
    logic [31:0]            inc32;
    logic [ANGLE_BITS-1:0]  ang_sel;
    logic                   kept_in;
    logic [31:0]            a32;
    logic [31:0]            a_plus;
    logic                   flip;
    logic [31:0]            a_rot;
    logic [31:0]            gain_prod;
    logic signed [XY_W-1:0] x0;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [32:0]     atan_z;
    logic signed [XY_W-1:0] x_rnd;
    logic signed [XY_W-1:0] y_rnd;
    logic signed [16:0]     x_sat;
    logic signed [16:0]     y_sat;
    logic signed [16:0]     pix_mm;
    logic signed [33:0]     pix_prod;
    logic signed [PIX_W-1:0] pix_sum;
    logic signed [PIX_W-17:0] pix_coord;
    logic                   pix_ok;

    // Clamp a rounded coordinate to +/-65535 mm
    function automatic logic signed [16:0] sat_mm(input logic signed [XY_W-1:0] v);
        logic signed [16:0] res;
        priority if (v > XY_W'(65535)) begin
            res = 17'sd65535;
        end else if (v < -XY_W'(65535)) begin
            res = -17'sd65535;
        end else begin
            res = v[16:0];
        end
        return res;
    endfunction

    // Angle selection and range gate at accept
    assign start32 = {16'h0, i_cfg.angle_start};
    assign inc32   = {{16{i_cfg.angle_inc[15]}}, i_cfg.angle_inc};
    assign ang_sel = r_at_start ? start32[ANGLE_BITS-1:0] : r_cur_angle;
    assign kept_in = !i_range_bad && (i_range_mm > i_cfg.range_min)
                     && (i_range_mm <= i_cfg.range_max);

    // Fold the angle into the right half plane and scale by the gain
    assign a32       = {r_ang, {PAD_W{1'b0}}};
    assign a_plus    = a32 + 32'h4000_0000;
    assign flip      = a_plus[31];
    assign a_rot     = flip ? (a32 ^ 32'h8000_0000) : a32;
    assign gain_prod = {16'h0, r_range} * {16'h0, GAIN_Q16};
    assign x0        = flip ? -$signed({3'b000, gain_prod}) : $signed({3'b000, gain_prod});

    // One CORDIC micro-rotation
    assign dx     = r_y >>> r_cnt;
    assign dy     = r_x >>> r_cnt;
    assign atan_z = $signed({1'b0, atan_turn(5'(r_cnt))});

    // Round half up to mm and clamp
    assign x_rnd = (r_x + XY_W'(32768)) >>> 16;
    assign y_rnd = (r_y + XY_W'(32768)) >>> 16;
    assign x_sat = sat_mm(x_rnd);
    assign y_sat = sat_mm(y_rnd);

    // Shared projection: floor(mm * scale / 2^16 + size / 2)
    assign pix_mm    = i_cmd.pix_v ? r_y_mm : r_x_mm;
    assign pix_prod  = 34'(pix_mm) * 34'($signed({1'b0, i_cfg.pixel_scale}));
    assign pix_sum   = PIX_W'(pix_prod) + $signed({8'h0, i_cfg.img_dim, 15'h0});
    assign pix_coord = pix_sum[PIX_W-1:16];
    assign pix_ok    = !pix_coord[PIX_W-17]
                       && (pix_coord[PIX_W-18:0] < {{(PIX_W-29){1'b0}}, i_cfg.img_dim});

    // Scan state: advance angle on every word, track kept points per scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_angle <= '0;
            r_at_start  <= 1'b1;
            r_any_kept  <= 1'b0;
        end else if (i_cmd.accept) begin
            r_cur_angle <= ang_sel + inc32[ANGLE_BITS-1:0];
            r_at_start  <= i_scan_last;
            r_any_kept  <= !i_scan_last && (r_any_kept || kept_in);
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_range <= i_range_mm;
            r_ang   <= ang_sel;
            r_kept  <= kept_in;
            r_last  <= i_scan_last;
            r_empty <= !(r_any_kept || kept_in);
            r_x_mm  <= '0;
            r_y_mm  <= '0;
            r_u     <= '0;
            r_v     <= '0;
            r_on    <= 1'b0;
        end
        if (i_cmd.prep) begin
            r_x   <= x0;
            r_y   <= '0;
            r_z   <= $signed({a_rot[31], a_rot});
            r_cnt <= '0;
        end
        if (i_cmd.iter) begin
            if (!r_z[32]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_z;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_z;
            end
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.round) begin
            r_x_mm <= x_sat;
            r_y_mm <= y_sat;
        end
        if (i_cmd.pix_u) begin
            r_u    <= pix_coord[11:0];
            r_u_ok <= pix_ok;
        end
        if (i_cmd.pix_v) begin
            r_on <= r_u_ok && pix_ok;
            if (r_u_ok && pix_ok) begin
                r_v <= pix_coord[11:0];
            end else begin
                r_u <= '0;
                r_v <= '0;
            end
        end
    end

    // Output word register: load when free, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_x     <= r_x_mm;
            r_out_y     <= r_y_mm;
            r_out_u     <= r_u;
            r_out_v     <= r_v;
            r_out_on    <= r_on;
            r_out_pv    <= r_kept;
            r_out_end   <= r_last;
            r_out_empty <= r_last && r_empty;
        end
    end

    assign o_sts.kept      = r_kept;
    assign o_sts.last      = r_last;
    assign o_sts.iter_last = (r_cnt == LAST_ITER);
    assign o_sts.out_free  = !r_out_valid || !i_stall;

    assign o_valid       = r_out_valid;
    assign o_point_x_mm  = r_out_x;
    assign o_point_y_mm  = r_out_y;
    assign o_pixel_u     = r_out_u;
    assign o_pixel_v     = r_out_v;
    assign o_on_image    = r_out_on;
    assign o_point_valid = r_out_pv;
    assign o_scan_end    = r_out_end;
    assign o_scan_empty  = r_out_empty;

endmodule

// ===== src/lidar_scan_to_points.sv =====
// Lidar scan to points: range samples in, Cartesian points and image pixels out.
// Instantiates lsp_regs, lsp_ctrl and lsp_dp; uses lsp_pkg.
//
// Input channel: i_valid / o_stall carry one range word (i_range_mm, i_range_bad,
// i_scan_last). Output channel: o_valid / i_stall carry one result word.
// A word moves on a rising edge with valid high and stall low.
// Each input word advances the scan angle. A word that passes the range gate
// gives a point word; the last word of a scan always gives a word, with
// o_scan_end set and o_scan_empty set when the scan kept nothing.
// Sequence: a kept sample goes through the PREP, ITER, ROUND, PIX_U, PIX_V and
// DONE states before it shows on o_valid, and the block takes no new word until
// it is back in IDLE, as the iterative CORDIC shares one add/shift unit.
// A dropped sample returns to IDLE after PREP; a dropped last one goes to DONE.
// The output word register lets the next sample start while a result is held;
// while i_stall is high the result holds and the block stops before its own
// output load. Reset clears the scan state and the registers to their reset
// values; no clearing pass is needed. Configure over APB only while idle.
module lidar_scan_to_points import lsp_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_BITS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_range_mm,
    input  logic               i_range_bad,
    input  logic               i_scan_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [16:0] o_point_x_mm,
    output logic signed [16:0] o_point_y_mm,
    output logic [11:0]        o_pixel_u,
    output logic [11:0]        o_pixel_v,
    output logic               o_on_image,
    output logic               o_point_valid,
    output logic               o_scan_end,
    output logic               o_scan_empty
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    lsp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lsp_dp #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_range_mm    (i_range_mm),
        .i_range_bad   (i_range_bad),
        .i_scan_last   (i_scan_last),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_point_x_mm  (o_point_x_mm),
        .o_point_y_mm  (o_point_y_mm),
        .o_pixel_u     (o_pixel_u),
        .o_pixel_v     (o_pixel_v),
        .o_on_image    (o_on_image),
        .o_point_valid (o_point_valid),
        .o_scan_end    (o_scan_end),
        .o_scan_empty  (o_scan_empty)
    );

endmodule

// ===== src/lsp_checker.sv =====
// Port-level checker for lidar_scan_to_points, attached by the bind below.
// Sees only the top-level ports; no package dependency.
module lsp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [16:0] o_point_x_mm,
    input logic signed [16:0] o_point_y_mm,
    input logic [11:0]        o_pixel_u,
    input logic [11:0]        o_pixel_v,
    input logic               o_on_image,
    input logic               o_point_valid,
    input logic               o_scan_end,
    input logic               o_scan_empty
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_point_x_mm) && $stable(o_point_y_mm)
            && $stable(o_pixel_u) && $stable(o_scan_end))
        else $error("result word changed while stalled");

    // Busy in the cycle after taking a sample
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("sample taken on two consecutive cycles");

    // Off-image points carry zero pixel coordinates
    a_off_image_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_on_image |-> o_pixel_u == 12'd0 && o_pixel_v == 12'd0)
        else $error("off-image point with non-zero pixel");

    // A word without a point is a zeroed scan end
    a_no_point_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_point_valid |-> o_scan_end && !o_on_image
            && o_point_x_mm == 17'sd0 && o_point_y_mm == 17'sd0)
        else $error("result without point is not a clean scan end");

    // Empty flag only on a scan end without point
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_scan_empty |-> o_scan_end && !o_point_valid)
        else $error("scan_empty on a word that is not an empty scan end");

endmodule

bind lidar_scan_to_points lsp_checker u_lsp_checker (.*);
